// File: design/rms_sound_level_meter_macros.svh
// Assertion macros for the RMS sound level meter checker.
// The macros expect clk, and RSLM_ASSERT also rst_n, in the scope of use.
`ifndef RMS_SOUND_LEVEL_METER_MACROS_SVH
`define RMS_SOUND_LEVEL_METER_MACROS_SVH

// Checked only while the block is out of reset.
`define RSLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RSLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rslm_pkg.sv
// Shared types and fixed widths for the RMS sound level meter.
// No dependencies; rslm_sq_acc, the top level and the checker import this package.
package rslm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SQR_W    = 2 * SAMPLE_W;
  localparam int SPW_W    = 11;
  localparam int WPM_W    = 7;
  localparam int MID_W    = 12;
  localparam int STEP_W   = 16;
  localparam int CFG_W    = 16;
  localparam int LEVEL_W  = 13;
  localparam int INT_W    = 10;
  localparam int X16_W    = LEVEL_W + 4;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    CFG_SPW,
    CFG_WPM,
    CFG_MID,
    CFG_STEP
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] window_level;
    logic               measure_done;
    logic [INT_W-1:0]   mean_intensity;
    logic [INT_W-1:0]   peak_steps;
  } rslm_result_t;

endpackage

// File: design/rslm_stream_if.sv
// Valid/ready stream interface used for the sample and result channels.
// The payload type is chosen by the instantiating scope.
interface rslm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// File: design/rslm_sq_acc.sv
// Bit-serial squarer that adds the square of one sample into a running sum.
// Depends on rslm_pkg for the sample width.
module rslm_sq_acc #(
  parameter int SUM_W = 35
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              clear,
  input  rslm_pkg::sample_t sample,
  output logic              done,
  output logic [SUM_W-1:0]  sum
);
  import rslm_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_W + 1);

  logic [SQR_W-1:0]    mcand_r;
  logic [SAMPLE_W-1:0] mplier_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [SUM_W-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (clear) begin
        sum_r <= '0;
      end else if (busy_r && mplier_r[0]) begin
        sum_r <= sum_r + SUM_W'(mcand_r);
      end
      if (start && !busy_r) begin
        busy_r   <= 1'b1;
        cnt_r    <= CNT_W'(SAMPLE_W);
        mcand_r  <= SQR_W'(sample);
        mplier_r <= sample;
      end else if (busy_r) begin
        mcand_r  <= {mcand_r[SQR_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[SAMPLE_W-1:1]};
        cnt_r    <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

// File: design/rslm_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on nothing but its parameters; the divisor must be non-zero.
module rslm_divider #(
  parameter int DVD_W = 35,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             take;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    take    = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], take};
        rem_r <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/rslm_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on nothing but its parameter; the result is the floor of the root.
module rslm_isqrt #(
  parameter int IN_W = 35
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [IN_W-1:0]         radicand,
  output logic                    done,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int RT_W  = (IN_W + 1) / 2;
  localparam int PAD_W = 2 * RT_W;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [PAD_W-1:0] rad_r;
  logic [RT_W:0]    rem_r;
  logic [RT_W-1:0]  root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RT_W+2:0]  rem_sh;
  logic [RT_W+2:0]  trial;
  logic [RT_W+2:0]  diff;
  logic             take;

  always_comb begin
    rem_sh = {rem_r, rad_r[PAD_W-1:PAD_W-2]};
    trial  = {1'b0, root_r, 2'b01};
    diff   = rem_sh - trial;
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RT_W);
        rad_r  <= PAD_W'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[PAD_W-3:0], 2'b00};
        rem_r  <= take ? diff[RT_W:0] : rem_sh[RT_W:0];
        root_r <= {root_r[RT_W-2:0], take};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: design/rms_sound_level_meter.sv
// Top level of the RMS sound level meter: configuration, sequencer and result register.
// Depends on rslm_pkg, rslm_stream_if, rslm_sq_acc, rslm_divider and rslm_isqrt.
//
//   channel   direction  handshake             beat
//   in_s      sink       valid/ready           one 12-bit sample
//   out_s     source     valid/ready           one window result
//   cfg_*     sink       cfg_we, no wait       one register write
//
// Each sample goes through the bit-serial squarer before the next beat is taken.
// The last sample of a window adds a division and a square root,
// and the last window of a measurement three more divisions.
// Reset is synchronous; a held result stalls only the closing of the next window.
module rms_sound_level_meter #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_WINDOWS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rslm_stream_if.sink                in_s,
  rslm_stream_if.source              out_s,
  input  logic                       cfg_we,
  input  rslm_pkg::cfg_idx_t         cfg_index,
  input  logic [rslm_pkg::CFG_W-1:0] cfg_wdata
);
  import rslm_pkg::*;

  localparam int SPW_MAX = (1 << SPW_W) - 1;
  localparam int NLIM    = (MAX_SAMPLES < SPW_MAX) ? MAX_SAMPLES : SPW_MAX;
  localparam int CNT_W   = $clog2(NLIM + 1);
  localparam int SUM_W   = SQR_W + CNT_W;
  localparam int WPM_MAX = (1 << WPM_W) - 1;
  localparam int WLIM    = (MAX_WINDOWS < WPM_MAX) ? MAX_WINDOWS : WPM_MAX;
  localparam int WC_W    = $clog2(WLIM + 1);
  localparam int LSUM_W  = LEVEL_W + WC_W;
  localparam int MDVD_W  = LSUM_W + 4;
  localparam int DVD_A   = (SUM_W > MDVD_W) ? SUM_W : MDVD_W;
  localparam int DVD_W   = (DVD_A > X16_W) ? DVD_A : X16_W;
  localparam int DVS_A   = (CNT_W > WC_W) ? CNT_W : WC_W;
  localparam int DVS_W   = (DVS_A > STEP_W) ? DVS_A : STEP_W;
  localparam int RT_W    = (SUM_W + 1) / 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_CHECK,
    S_DIV_MS,
    S_SQRT,
    S_LEVEL,
    S_DIV_MEAN,
    S_INT_MEAN,
    S_INT_PEAK,
    S_OUT
  } state_t;

  logic [SPW_W-1:0]  spw_r;
  logic [WPM_W-1:0]  wpm_r;
  logic [MID_W-1:0]  mid_r;
  logic [STEP_W-1:0] step_r;

  state_t            state_r;
  sample_t           sample_r;
  logic              sq_start_r;
  logic              div_start_r;
  logic              rt_start_r;
  logic [DVD_W-1:0]  div_dvd_r;
  logic [DVS_W-1:0]  div_dvs_r;
  logic [CNT_W-1:0]  count_r;
  logic [WC_W-1:0]   wc_r;
  logic [LSUM_W-1:0] lsum_r;
  logic [LEVEL_W-1:0] peak_r;
  logic [LEVEL_W-1:0] peak_keep_r;
  logic              zero_r;
  rslm_result_t      res_r;
  rslm_result_t      out_data_r;
  logic              out_valid_r;

  logic              sq_done;
  logic              sq_clear;
  logic [SUM_W-1:0]  sq_sum;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic              rt_done;
  logic [RT_W-1:0]   rt_root;

  logic [CNT_W-1:0]   spw_eff;
  logic [WC_W-1:0]    wpm_eff;
  logic [STEP_W-1:0]  step_eff;
  logic [CNT_W-1:0]   n_cnt;
  logic               window_end;
  logic [SAMPLE_W-1:0] rms;
  logic [SAMPLE_W-1:0] rms_dev;
  logic [LEVEL_W-1:0] level;
  logic [LSUM_W-1:0]  lsum_upd;
  logic [LEVEL_W-1:0] peak_upd;
  logic [WC_W-1:0]    wc_upd;
  logic               measure_end;
  logic [MDVD_W-1:0]  mean_dvd;
  logic [X16_W-1:0]   quo_x16;
  logic [X16_W-1:0]   mean_dec;
  logic [X16_W-1:0]   peak_x16;
  logic [X16_W-1:0]   peak_dec;
  logic [INT_W-1:0]   quo_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spw_r  <= SPW_W'(200);
      wpm_r  <= WPM_W'(20);
      mid_r  <= MID_W'(2048);
      step_r <= STEP_W'(655);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPW:  spw_r  <= cfg_wdata[SPW_W-1:0];
        CFG_WPM:  wpm_r  <= cfg_wdata[WPM_W-1:0];
        CFG_MID:  mid_r  <= cfg_wdata[MID_W-1:0];
        CFG_STEP: step_r <= cfg_wdata[STEP_W-1:0];
      endcase
    end
  end

  always_comb begin
    spw_eff     = (spw_r == '0) ? CNT_W'(1) :
                  ((int'(spw_r) > NLIM) ? CNT_W'(NLIM) : CNT_W'(spw_r));
    wpm_eff     = (wpm_r == '0) ? WC_W'(1) :
                  ((int'(wpm_r) > WLIM) ? WC_W'(WLIM) : WC_W'(wpm_r));
    step_eff    = (step_r == '0) ? STEP_W'(1) : step_r;
    n_cnt       = count_r + CNT_W'(1);
    window_end  = n_cnt >= spw_eff;
    rms         = rt_root[SAMPLE_W-1:0];
    rms_dev     = (rms >= mid_r) ? (rms - mid_r) : (mid_r - rms);
    level       = {rms_dev, 1'b0};
    lsum_upd    = lsum_r + LSUM_W'(level);
    peak_upd    = (level > peak_r) ? level : peak_r;
    wc_upd      = wc_r + WC_W'(1);
    measure_end = wc_upd >= wpm_eff;
    mean_dvd    = {lsum_upd, 4'b0000};
    quo_x16     = div_quo[X16_W-1:0];
    mean_dec    = quo_x16 - X16_W'(1);
    peak_x16    = {peak_keep_r, 4'b0000};
    peak_dec    = peak_x16 - X16_W'(1);
    quo_sat     = (|div_quo[DVD_W-1:INT_W]) ? '1 : div_quo[INT_W-1:0];
    sq_clear    = (state_r == S_CHECK) && window_end;
  end

  rslm_sq_acc #(
    .SUM_W (SUM_W)
  ) u_sq_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start_r),
    .clear  (sq_clear),
    .sample (sample_r),
    .done   (sq_done),
    .sum    (sq_sum)
  );

  rslm_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  rslm_isqrt #(
    .IN_W (SUM_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start_r),
    .radicand (div_quo[SUM_W-1:0]),
    .done     (rt_done),
    .root     (rt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sq_start_r  <= 1'b0;
      div_start_r <= 1'b0;
      rt_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      wc_r        <= '0;
      lsum_r      <= '0;
      peak_r      <= '0;
    end else begin
      sq_start_r  <= (state_r == S_IDLE) && in_s.valid;
      rt_start_r  <= (state_r == S_DIV_MS) && div_done;
      div_start_r <= ((state_r == S_CHECK) && window_end) ||
                     ((state_r == S_LEVEL) && measure_end) ||
                     (((state_r == S_DIV_MEAN) || (state_r == S_INT_MEAN)) && div_done);
      out_valid_r <= (state_r == S_OUT) || (out_valid_r && !out_s.ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_s.valid) begin
            sample_r <= in_s.data;
            state_r  <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (sq_done) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!window_end) begin
            count_r <= n_cnt;
            state_r <= S_IDLE;
          end else begin
            count_r   <= '0;
            div_dvd_r <= DVD_W'(sq_sum);
            div_dvs_r <= DVS_W'(n_cnt);
            state_r   <= S_DIV_MS;
          end
        end
        S_DIV_MS: begin
          if (div_done) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rt_done) begin
            state_r <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          res_r.window_level   <= level;
          res_r.measure_done   <= measure_end;
          res_r.mean_intensity <= '0;
          res_r.peak_steps     <= '0;
          if (measure_end) begin
            wc_r        <= '0;
            lsum_r      <= '0;
            peak_r      <= '0;
            peak_keep_r <= peak_upd;
            div_dvd_r   <= DVD_W'(mean_dvd);
            div_dvs_r   <= DVS_W'(wc_upd);
            state_r     <= S_DIV_MEAN;
          end else begin
            wc_r    <= wc_upd;
            lsum_r  <= lsum_upd;
            peak_r  <= peak_upd;
            state_r <= S_OUT;
          end
        end
        S_DIV_MEAN: begin
          if (div_done) begin
            zero_r    <= (quo_x16 == '0);
            div_dvd_r <= DVD_W'(mean_dec);
            div_dvs_r <= DVS_W'(step_eff);
            state_r   <= S_INT_MEAN;
          end
        end
        S_INT_MEAN: begin
          if (div_done) begin
            res_r.mean_intensity <= zero_r ? '0 : quo_sat;
            zero_r               <= (peak_keep_r == '0);
            div_dvd_r            <= DVD_W'(peak_dec);
            div_dvs_r            <= DVS_W'(step_eff);
            state_r              <= S_INT_PEAK;
          end
        end
        S_INT_PEAK: begin
          if (div_done) begin
            res_r.peak_steps <= zero_r ? '0 : quo_sat;
            state_r          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_s.ready) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_s.ready  = (state_r == S_IDLE);
  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

endmodule

// File: design/rslm_checker.sv
// Port-level assertions for the RMS sound level meter, bound to the top level.
// Depends on rslm_pkg and the assertion macros in rms_sound_level_meter_macros.svh.
`include "rms_sound_level_meter_macros.svh"

module rslm_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input rslm_pkg::rslm_result_t out_data
);
  import rslm_pkg::*;

  `RSLM_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")
  `RSLM_ASSERT(a_one_sample, in_valid && in_ready |=> !in_ready, "second sample taken at once")
  `RSLM_ASSERT(a_quiet_fields, out_valid && !out_data.measure_done |-> out_data.mean_intensity == '0 && out_data.peak_steps == '0, "intensities set without measure end")
  `RSLM_ASSERT(a_mean_le_peak, out_valid && out_data.measure_done |-> out_data.mean_intensity <= out_data.peak_steps, "mean intensity above peak")
  `RSLM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind rms_sound_level_meter rslm_checker u_rslm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  (out_s.data)
);
